// ----- rtl/tsi3d_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the 3D turtle symbol interpreter.
package tsi3d_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int RES_FIFO_DEPTH  = 4;     // power of two
    localparam int POS_W           = 32;
    localparam int HEAD_W          = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    // command bytes
    localparam logic [7:0] SYM_FWD       = 8'h46;  // F
    localparam logic [7:0] SYM_YAW_POS   = 8'h2B;  // +
    localparam logic [7:0] SYM_YAW_NEG   = 8'h2D;  // -
    localparam logic [7:0] SYM_PITCH_POS = 8'h5E;  // ^
    localparam logic [7:0] SYM_PITCH_NEG = 8'h26;  // &
    localparam logic [7:0] SYM_ROLL_POS  = 8'h3E;  // >
    localparam logic [7:0] SYM_ROLL_NEG  = 8'h3C;  // <
    localparam logic [7:0] SYM_PUSH      = 8'h5B;  // [
    localparam logic [7:0] SYM_POP       = 8'h5D;  // ]

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COS_ALPHA = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIN_ALPHA = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    // rotation axes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [HEAD_W-1:0] HEAD_UNIT = 16'sd16384;
    localparam logic signed [HEAD_W-1:0] COS_RESET = 16'sd16384;

    typedef struct packed {
        logic [1:0] axis;
        logic       neg;
    } rot_cmd_t;

    typedef struct packed {
        logic             last;
        logic [1:0]       status;
        logic [POS_W-1:0] pos_z;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
    } res_t;

endpackage

// ----- rtl/tsi3d_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tsi3d_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tsi3d_rotate.sv -----
`timescale 1ns / 1ps
// Heading rotation about one axis: four Q2.14 products, round to nearest, saturate.
module tsi3d_rotate (
    input  logic signed [15:0] cos_alpha,
    input  logic signed [15:0] sin_alpha,
    input  logic signed [15:0] head_x,
    input  logic signed [15:0] head_y,
    input  logic signed [15:0] head_z,
    input  tsi3d_pkg::rot_cmd_t cmd,
    output logic signed [15:0] rot_x,
    output logic signed [15:0] rot_y,
    output logic signed [15:0] rot_z
);

    logic signed [16:0] c17, s17, a17, b17;
    logic signed [33:0] p_ca, p_sb, p_sa, p_cb;
    logic signed [15:0] new_a, new_b;

    // add half an LSB, floor shift by 14, clamp to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [34:0] v);
        logic signed [34:0] t;
        logic signed [20:0] q;
        t = v + 35'sd8192;
        q = t[34:14];
        if (q[20:15] != {6{q[15]}})
            return q[20] ? 16'sh8000 : 16'sh7fff;
        return q[15:0];
    endfunction

    // (a, b) is the rotated pair: a' = c*a - s*b, b' = s*a + c*b
    always_comb
    begin
        c17 = 17'(cos_alpha);
        s17 = cmd.neg ? -17'(sin_alpha) : 17'(sin_alpha);
        case (cmd.axis)
            tsi3d_pkg::AXIS_Y:
            begin
                a17 = 17'(head_z);
                b17 = 17'(head_x);
            end
            tsi3d_pkg::AXIS_X:
            begin
                a17 = 17'(head_y);
                b17 = 17'(head_z);
            end
            default:
            begin
                a17 = 17'(head_x);
                b17 = 17'(head_y);
            end
        endcase
        p_ca  = c17 * a17;
        p_sb  = s17 * b17;
        p_sa  = s17 * a17;
        p_cb  = c17 * b17;
        new_a = rnd_sat(35'(p_ca) - 35'(p_sb));
        new_b = rnd_sat(35'(p_sa) + 35'(p_cb));
    end

    always_comb
    begin
        rot_x = head_x;
        rot_y = head_y;
        rot_z = head_z;
        case (cmd.axis)
            tsi3d_pkg::AXIS_Z:
            begin
                rot_x = new_a;
                rot_y = new_b;
            end
            tsi3d_pkg::AXIS_Y:
            begin
                rot_z = new_a;
                rot_x = new_b;
            end
            tsi3d_pkg::AXIS_X:
            begin
                rot_y = new_a;
                rot_z = new_b;
            end
            default:
            begin
                rot_x = head_x;
            end
        endcase
    end

endmodule

// ----- rtl/tsi3d_out_fifo.sv -----
`timescale 1ns / 1ps
// Result FIFO: takes up to two words per cycle, hands out one.
module tsi3d_out_fifo #(
    parameter int DEPTH = tsi3d_pkg::RES_FIFO_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      wr_cnt,
    input  tsi3d_pkg::res_t wr_data0,
    input  tsi3d_pkg::res_t wr_data1,
    output logic            space2,
    output logic            out_valid,
    input  logic            out_ready,
    output tsi3d_pkg::res_t out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    tsi3d_pkg::res_t mem [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [LW-1:0] level_reg, level_next;
    logic          pop;

    assign out_valid = (level_reg != '0);
    assign out_data  = mem[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign space2    = (level_reg <= LW'(DEPTH - 2));
    assign level_next = level_reg + LW'(wr_cnt) - LW'(pop);

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem[wptr_reg] <= wr_data0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem[AW'(wptr_reg + AW'(1))] <= wr_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            wptr_reg  <= AW'(wptr_reg + AW'(wr_cnt));
            rptr_reg  <= AW'(rptr_reg + AW'(pop));
            level_reg <= level_next;
        end
    end

endmodule

// ----- rtl/turtle_symbol_interpreter_3d_core.sv -----
`timescale 1ns / 1ps
// 3D turtle interpreter: symbol decode, position/heading update, position stack.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: symbol[7:0]; tuser: start_req
//  m_*     | out | m_tvalid/m_tready | tdata: pos_x, pos_y, pos_z; tuser: status;
//          |     |                   | tlast: last
//  cfg_*   | in  | cfg_we            | cfg_addr: register index; cfg_wdata
//
//  One symbol word is taken per cycle while s_tready is high; turtle state updates at
//  the accepting edge, and its results are written into a 4-word FIFO at that edge.
//  A start word plus an emitting symbol gives two result words; the single output port
//  then sets the sustained rate to one result word per cycle while m_tready is high.
//  s_tready drops only when the result FIFO has fewer than two free slots.
//  The stack top sits in registers; deeper entries live in a RAM prefetched at count-2.
//  No clearing pass after reset.
module turtle_symbol_interpreter_3d_core #(
    parameter int STACK_DEPTH = tsi3d_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] symbol
    input  logic        s_tuser,    // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
    output logic [1:0]  m_tuser,    // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [tsi3d_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tsi3d_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int PW    = tsi3d_pkg::POS_W;
    localparam int HW    = tsi3d_pkg::HEAD_W;
    localparam int WORDW = 3 * PW;

    // configuration
    logic signed [PW-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [HW-1:0] cos_reg, sin_reg;

    // turtle state
    logic signed [PW-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [PW-1:0] cur_x_next, cur_y_next, cur_z_next;
    logic signed [HW-1:0] head_x_reg, head_y_reg, head_z_reg;
    logic signed [HW-1:0] head_x_next, head_y_next, head_z_next;
    logic [CW-1:0]        stk_cnt_reg, stk_cnt_next, cnt_eff;
    logic [WORDW-1:0]     top_reg, top_next;
    logic                 byp_reg;
    logic [WORDW-1:0]     byp_data_reg;

    logic                 accept, start;
    logic [7:0]           sym;
    logic signed [PW-1:0] base_x, base_y, base_z;
    logic signed [HW-1:0] base_hx, base_hy, base_hz;
    logic [CW-1:0]        base_cnt;

    logic                 is_fwd, is_rot, is_push, is_pop;
    logic                 push_ok, pop_ok;
    tsi3d_pkg::rot_cmd_t  rot_cmd;
    logic signed [HW-1:0] rot_x, rot_y, rot_z;

    logic signed [PW:0]   sum_x, sum_y, sum_z;
    logic [PW-1:0]        fwd_x, fwd_y, fwd_z;
    logic                 fwd_sat;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORDW-1:0]     ram_wdata, ram_rdata, below;

    logic                 sym_emit;
    tsi3d_pkg::res_t      res_start, res_sym, wr_data0, out_word;
    logic [1:0]           wr_cnt;
    logic                 space2;

    function automatic logic [PW-1:0] sat_pos(input logic signed [PW:0] v);
        if (v[PW] != v[PW-1])
            return v[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        return v[PW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            cos_reg      <= tsi3d_pkg::COS_RESET;
            sin_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tsi3d_pkg::CFG_ORIGIN_X:  origin_x_reg <= cfg_wdata[PW-1:0];
                tsi3d_pkg::CFG_ORIGIN_Y:  origin_y_reg <= cfg_wdata[PW-1:0];
                tsi3d_pkg::CFG_ORIGIN_Z:  origin_z_reg <= cfg_wdata[PW-1:0];
                tsi3d_pkg::CFG_COS_ALPHA: cos_reg      <= cfg_wdata[HW-1:0];
                tsi3d_pkg::CFG_SIN_ALPHA: sin_reg      <= cfg_wdata[HW-1:0];
                default:                  ;
            endcase
        end
    end

    assign s_tready = space2;
    assign accept   = s_tvalid && s_tready;
    assign sym      = s_tdata;
    assign start    = s_tuser;

    // a start request homes the turtle before the symbol is handled
    assign base_x   = start ? origin_x_reg : cur_x_reg;
    assign base_y   = start ? origin_y_reg : cur_y_reg;
    assign base_z   = start ? origin_z_reg : cur_z_reg;
    assign base_hx  = start ? '0 : head_x_reg;
    assign base_hy  = start ? '0 : head_y_reg;
    assign base_hz  = start ? tsi3d_pkg::HEAD_UNIT : head_z_reg;
    assign base_cnt = start ? '0 : stk_cnt_reg;

    always_comb
    begin
        is_fwd  = 1'b0;
        is_rot  = 1'b0;
        is_push = 1'b0;
        is_pop  = 1'b0;
        rot_cmd = '{axis: tsi3d_pkg::AXIS_Z, neg: 1'b0};
        case (sym)
            tsi3d_pkg::SYM_FWD:       is_fwd = 1'b1;
            tsi3d_pkg::SYM_YAW_POS:
            begin
                is_rot  = 1'b1;
                rot_cmd = '{axis: tsi3d_pkg::AXIS_Z, neg: 1'b0};
            end
            tsi3d_pkg::SYM_YAW_NEG:
            begin
                is_rot  = 1'b1;
                rot_cmd = '{axis: tsi3d_pkg::AXIS_Z, neg: 1'b1};
            end
            tsi3d_pkg::SYM_PITCH_POS:
            begin
                is_rot  = 1'b1;
                rot_cmd = '{axis: tsi3d_pkg::AXIS_Y, neg: 1'b0};
            end
            tsi3d_pkg::SYM_PITCH_NEG:
            begin
                is_rot  = 1'b1;
                rot_cmd = '{axis: tsi3d_pkg::AXIS_Y, neg: 1'b1};
            end
            tsi3d_pkg::SYM_ROLL_POS:
            begin
                is_rot  = 1'b1;
                rot_cmd = '{axis: tsi3d_pkg::AXIS_X, neg: 1'b0};
            end
            tsi3d_pkg::SYM_ROLL_NEG:
            begin
                is_rot  = 1'b1;
                rot_cmd = '{axis: tsi3d_pkg::AXIS_X, neg: 1'b1};
            end
            tsi3d_pkg::SYM_PUSH:      is_push = 1'b1;
            tsi3d_pkg::SYM_POP:       is_pop  = 1'b1;
            default:                  ;
        endcase
    end

    tsi3d_rotate u_rotate (
        .cos_alpha (cos_reg),
        .sin_alpha (sin_reg),
        .head_x    (base_hx),
        .head_y    (base_hy),
        .head_z    (base_hz),
        .cmd       (rot_cmd),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z)
    );

    // heading is Q2.14, position Q16.16: scale by 4
    assign sum_x   = (PW+1)'(base_x) + (PW+1)'($signed({base_hx, 2'b00}));
    assign sum_y   = (PW+1)'(base_y) + (PW+1)'($signed({base_hy, 2'b00}));
    assign sum_z   = (PW+1)'(base_z) + (PW+1)'($signed({base_hz, 2'b00}));
    assign fwd_x   = sat_pos(sum_x);
    assign fwd_y   = sat_pos(sum_y);
    assign fwd_z   = sat_pos(sum_z);
    assign fwd_sat = (sum_x[PW] != sum_x[PW-1]) || (sum_y[PW] != sum_y[PW-1])
                  || (sum_z[PW] != sum_z[PW-1]);

    assign push_ok = is_push && (base_cnt < CW'(STACK_DEPTH));
    assign pop_ok  = is_pop && (base_cnt != '0);

    // same-edge write to the prefetch address is forwarded
    assign below = byp_reg ? byp_data_reg : ram_rdata;

    always_comb
    begin
        cur_x_next   = base_x;
        cur_y_next   = base_y;
        cur_z_next   = base_z;
        head_x_next  = base_hx;
        head_y_next  = base_hy;
        head_z_next  = base_hz;
        stk_cnt_next = base_cnt;
        top_next     = top_reg;
        if (is_fwd)
        begin
            cur_x_next = fwd_x;
            cur_y_next = fwd_y;
            cur_z_next = fwd_z;
        end
        if (is_rot)
        begin
            head_x_next = rot_x;
            head_y_next = rot_y;
            head_z_next = rot_z;
        end
        if (push_ok)
        begin
            top_next     = {base_z, base_y, base_x};
            stk_cnt_next = base_cnt + CW'(1);
        end
        if (pop_ok)
        begin
            cur_x_next   = top_reg[PW-1:0];
            cur_y_next   = top_reg[2*PW-1:PW];
            cur_z_next   = top_reg[3*PW-1:2*PW];
            top_next     = below;
            stk_cnt_next = base_cnt - CW'(1);
        end
    end

    // old top spills to RAM on push; RAM read always tracks entry count-2
    assign cnt_eff   = accept ? stk_cnt_next : stk_cnt_reg;
    assign ram_we    = accept && push_ok && (base_cnt != '0);
    assign ram_waddr = AW'(base_cnt - CW'(1));
    assign ram_wdata = top_reg;
    assign ram_raddr = AW'(cnt_eff - CW'(2));

    tsi3d_ram #(
        .WIDTH (WORDW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            cur_z_reg   <= '0;
            head_x_reg  <= '0;
            head_y_reg  <= '0;
            head_z_reg  <= tsi3d_pkg::HEAD_UNIT;
            stk_cnt_reg <= '0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            byp_reg <= ram_we && (ram_waddr == ram_raddr);
            if (accept)
            begin
                cur_x_reg   <= cur_x_next;
                cur_y_reg   <= cur_y_next;
                cur_z_reg   <= cur_z_next;
                head_x_reg  <= head_x_next;
                head_y_reg  <= head_y_next;
                head_z_reg  <= head_z_next;
                stk_cnt_reg <= stk_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg <= top_next;
        end
        if (ram_we)
        begin
            byp_data_reg <= ram_wdata;
        end
    end

    // result words
    assign sym_emit = is_fwd || (is_push && !push_ok) || (is_pop && !pop_ok);

    always_comb
    begin
        res_start = '{last: !sym_emit, status: tsi3d_pkg::ST_OK,
                      pos_z: origin_z_reg, pos_y: origin_y_reg, pos_x: origin_x_reg};
        res_sym   = '{last: 1'b1, status: tsi3d_pkg::ST_OK,
                      pos_z: base_z, pos_y: base_y, pos_x: base_x};
        if (is_fwd)
        begin
            res_sym.status = fwd_sat ? tsi3d_pkg::ST_SATURATED : tsi3d_pkg::ST_OK;
            res_sym.pos_x  = fwd_x;
            res_sym.pos_y  = fwd_y;
            res_sym.pos_z  = fwd_z;
        end
        else if (is_push)
        begin
            res_sym.status = tsi3d_pkg::ST_OVERFLOW;
        end
        else if (is_pop)
        begin
            res_sym.status = tsi3d_pkg::ST_UNDERFLOW;
        end
    end

    assign wr_cnt   = accept ? (2'(start) + 2'(sym_emit)) : 2'd0;
    assign wr_data0 = start ? res_start : res_sym;

    tsi3d_out_fifo #(
        .DEPTH (tsi3d_pkg::RES_FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (wr_cnt),
        .wr_data0  (wr_data0),
        .wr_data1  (res_sym),
        .space2    (space2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {out_word.pos_z, out_word.pos_y, out_word.pos_x};
    assign m_tuser = out_word.status;
    assign m_tlast = out_word.last;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser |=> m_tvalid)
        else $error("start word produced no result word");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tuser && (s_tdata == tsi3d_pkg::SYM_POP) && (stk_cnt_reg != '0)
        |=> stk_cnt_reg == CW'($past(stk_cnt_reg) - CW'(1)))
        else $error("pop did not drop stack count");

endmodule
